### rtl/mexp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ---------------------------------------------------------------------------
package mexp_pkg;

	// field and register widths at the ports
	localparam int FIELD_W       = 32;
	localparam int DEFAULT_WIDTH = 32;
	localparam int ADDR_W        = 3;

	// register reset values
	localparam logic [FIELD_W-1:0] RESET_MODULUS  = 32'd16777215;
	localparam logic [FIELD_W-1:0] RESET_EXPONENT = 32'd65537;

	// register index, taken from paddr[2]
	localparam logic REG_MODULUS  = 1'b0;
	localparam logic REG_EXPONENT = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MULT,
		ST_SQUARE,
		ST_FINISH
	} state_t;

	// status from the serial multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

`default_nettype wire

### rtl/mexp_base_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mexp_base_if
// Valid/ready channel carrying the base word.
// ---------------------------------------------------------------------------
interface mexp_base_if;

	logic                           valid;
	logic                           ready;
	logic [mexp_pkg::FIELD_W-1:0]   base_value;

	modport source (output valid, output base_value, input ready);
	modport sink   (input valid, input base_value, output ready);

endinterface

`default_nettype wire

### rtl/mexp_result_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mexp_result_if
// Valid/ready channel carrying the result word.
// ---------------------------------------------------------------------------
interface mexp_result_if;

	logic                           valid;
	logic                           ready;
	logic [mexp_pkg::FIELD_W-1:0]   power_result;

	modport source (output valid, output power_result, input ready);
	modport sink   (input valid, input power_result, output ready);

endinterface

`default_nettype wire

### rtl/mexp_cfg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mexp_cfg
// APB register file: modulus (index 0) and exponent (index 1).
// ---------------------------------------------------------------------------
module mexp_cfg #(
	parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mexp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mexp_pkg::FIELD_W-1:0]  pwdata,
	output logic      [mexp_pkg::FIELD_W-1:0]  prdata,
	output logic                               pready,
	output logic      [WIDTH-1:0]              modulus,
	output logic      [WIDTH-1:0]              exponent
);

	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] exp_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes, low WIDTH bits kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= WIDTH'(mexp_pkg::RESET_MODULUS);
			exp_q <= WIDTH'(mexp_pkg::RESET_EXPONENT);
		end else if (wr_en) begin
			if (paddr[2] == mexp_pkg::REG_MODULUS) begin
				mod_q <= WIDTH'(pwdata);
			end else begin
				exp_q <= WIDTH'(pwdata);
			end
		end
	end

	// read back
	always_comb begin
		if (paddr[2] == mexp_pkg::REG_EXPONENT) begin
			prdata = mexp_pkg::FIELD_W'(exp_q);
		end else begin
			prdata = mexp_pkg::FIELD_W'(mod_q);
		end
	end

	assign modulus  = mod_q;
	assign exponent = exp_q;

endmodule

`default_nettype wire

### rtl/mexp_mulmod.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: p = a * b mod m, one bit of b
// per cycle, MSB first. Needs a < m and m nonzero; b may be any value.
// ---------------------------------------------------------------------------
module mexp_mulmod #(
	parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WIDTH-1:0]  op_a,
	input  wire logic [WIDTH-1:0]  op_b,
	input  wire logic [WIDTH-1:0]  modulus,
	output logic      [WIDTH-1:0]  product,
	output mexp_pkg::mul_stat_t    stat
);

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] acc_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] m1;
	logic [WIDTH+1:0] m2;
	logic [WIDTH-1:0] acc_nxt;

	// acc = 2*acc + (bit ? a : 0), below 3m, then one of three candidates
	always_comb begin
		m1  = {2'b00, modulus};
		m2  = {1'b0, modulus, 1'b0};
		sum = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[WIDTH-1] ? a_q : '0)};
		if (sum >= m2) begin
			acc_nxt = WIDTH'(sum - m2);
		end else if (sum >= m1) begin
			acc_nxt = WIDTH'(sum - m1);
		end else begin
			acc_nxt = WIDTH'(sum);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and accumulator shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
			acc_q <= acc_nxt;
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

### rtl/modular_exponentiation.sv
`default_nettype none
// ---------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: power_result = base_value^exponent
// mod modulus, on one shared bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// All work goes through one bit-serial modular multiplier. An item first
// reduces the base; then each exponent bit up to the highest set one takes
// a step, a multiply where the bit is set and a square, which is left out
// after the highest set bit; the result is then handed over. An exponent
// of zero, or a modulus of zero, is answered without the multiplier (1 and
// 0 respectively). One item is in work at a time; a finished word waits in
// an output register, so the next base is taken while the previous result
// is still unread. Write the modulus and exponent registers only while the
// block is idle.
module modular_exponentiation #(
	parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mexp_base_if.sink                          base_in,
	mexp_result_if.source                      result_out,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mexp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mexp_pkg::FIELD_W-1:0]  pwdata,
	output logic      [mexp_pkg::FIELD_W-1:0]  prdata,
	output logic                               pready
);

	mexp_pkg::state_t    state_q;
	mexp_pkg::state_t    state_nxt;
	mexp_pkg::mul_stat_t mstat;

	logic [WIDTH-1:0] modulus;
	logic [WIDTH-1:0] exponent;
	logic [WIDTH-1:0] x_in;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] sq_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] product;
	logic [WIDTH-1:0] op_a;
	logic [WIDTH-1:0] op_b;
	logic             mul_start;
	logic             accept;
	logic             last_bit;
	logic             out_free;
	logic             out_valid_q;
	logic [mexp_pkg::FIELD_W-1:0] out_data_q;

	mexp_cfg #(.WIDTH(WIDTH)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.modulus  (modulus),
		.exponent (exponent)
	);

	mexp_mulmod #(.WIDTH(WIDTH)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (op_a),
		.op_b    (op_b),
		.modulus (modulus),
		.product (product),
		.stat    (mstat)
	);

	assign x_in     = WIDTH'(base_in.base_value);
	assign accept   = base_in.valid & base_in.ready;
	assign last_bit = (e_q[WIDTH-1:1] == '0);
	assign out_free = !out_valid_q || result_out.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (accept) begin
					if (exponent == '0 || modulus == '0) begin
						state_nxt = mexp_pkg::ST_FINISH;
					end else begin
						state_nxt = mexp_pkg::ST_REDUCE;
					end
				end
			end
			mexp_pkg::ST_REDUCE: begin
				if (mstat.done) begin
					state_nxt = mexp_pkg::ST_STEP;
				end
			end
			mexp_pkg::ST_STEP: begin
				if (e_q == '0) begin
					state_nxt = mexp_pkg::ST_FINISH;
				end else if (e_q[0]) begin
					state_nxt = mexp_pkg::ST_MULT;
				end else begin
					state_nxt = mexp_pkg::ST_SQUARE;
				end
			end
			mexp_pkg::ST_MULT: begin
				if (mstat.done) begin
					state_nxt = last_bit ? mexp_pkg::ST_FINISH : mexp_pkg::ST_SQUARE;
				end
			end
			mexp_pkg::ST_SQUARE: begin
				if (mstat.done) begin
					state_nxt = mexp_pkg::ST_STEP;
				end
			end
			mexp_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nxt = mexp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mexp_pkg::ST_IDLE;
		endcase
	end

	// multiplier launch and operand selection
	always_comb begin
		base_in.ready = 1'b0;
		mul_start     = 1'b0;
		op_a          = sq_q;
		op_b          = sq_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				base_in.ready = 1'b1;
				// base mod m as (1 mod m) * x mod m
				op_a      = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
				op_b      = x_in;
				mul_start = accept && (exponent != '0) && (modulus != '0);
			end
			mexp_pkg::ST_STEP: begin
				mul_start = (e_q != '0);
				if (e_q[0]) begin
					op_a = acc_q;
				end
			end
			mexp_pkg::ST_MULT: begin
				mul_start = mstat.done && !last_bit;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// working values
	always_ff @(posedge clk) begin
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (accept) begin
					e_q <= exponent;
					if (exponent == '0) begin
						acc_q <= WIDTH'(1);
					end else if (modulus == '0 || modulus == WIDTH'(1)) begin
						acc_q <= '0;
					end else begin
						acc_q <= WIDTH'(1);
					end
				end
			end
			mexp_pkg::ST_REDUCE: begin
				if (mstat.done) begin
					sq_q <= product;
				end
			end
			mexp_pkg::ST_MULT: begin
				if (mstat.done) begin
					acc_q <= product;
				end
			end
			mexp_pkg::ST_SQUARE: begin
				if (mstat.done) begin
					sq_q <= product;
					e_q  <= e_q >> 1;
				end
			end
			default: begin
				e_q <= e_q;
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mexp_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mexp_pkg::ST_FINISH && out_free) begin
			out_data_q <= mexp_pkg::FIELD_W'(acc_q);
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.power_result = out_data_q;

endmodule

`default_nettype wire
